/* hdl/tcw_pkg.sv */
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;

   localparam logic [2:0] FUNC_CHAR       = 3'd0;
   localparam logic [2:0] FUNC_HEX_BYTE   = 3'd1;
   localparam logic [2:0] FUNC_HEX_WORD   = 3'd2;
   localparam logic [2:0] FUNC_HEX_DWORD  = 3'd3;
   localparam logic [2:0] FUNC_DECIMAL    = 3'd4;
   localparam logic [2:0] FUNC_SET_CURSOR = 3'd5;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;
   localparam logic [3:0] NIBBLE_NINE    = 4'h9;
   localparam logic [7:0] COLOUR_RESET   = 8'd15;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] value;
      logic [6:0]  new_column;
      logic [4:0]  new_row;
   } req_type;

   typedef struct packed {
      logic        cell_write;
      logic [10:0] cell_address;
      logic [15:0] cell_entry;
      logic [7:0]  serial_char;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load_char;
      logic load_hex;
      logic load_dec;
      logic set_cursor;
      logic convert_step;
      logic skip_digit;
      logic emit;
   } tcw_cmd_type;

   typedef struct packed {
      logic top_zero;
      logic count_one;
      logic bits_done;
      logic out_free;
   } tcw_status_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SKIP    = 4'b0100,
      ST_EMIT    = 4'b1000
   } tcw_state_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      if (nib > NIBBLE_NINE) begin
         return {4'h0, nib} + HEX_ALPHA_BASE;
      end
      return {4'h0, nib} + CHAR_ZERO;
   endfunction

endpackage

/* hdl/text_console_writer.sv */
// Console request engine: one request in at a time, printed characters out as items, one per
// cycle while the consumer takes them. A character request emits its byte as is and a hex
// byte/word/dword request emits 2/4/8 hex digits; a decimal request is taken, runs a
// binary-to-BCD shift-add conversion, skips leading zero digits one at a time, leaves the
// skip, then emits its digits; set cursor, negative decimal and unused codes stay in idle and
// give no item. Output back-pressure stalls emitting. The text colour is written through
// csr_write_enable/csr_write_data, by the user only while idle; the block does not enforce it.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_control u_control (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_func     (req_data.func),
      .req_negative (req_data.value[31]),
      .req_ready    (req_ready),
      .status       (status),
      .cmd          (cmd)
   );

   tcw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data)
   );

endmodule

/* hdl/tcw_control.sv */
module tcw_control
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [2:0]     req_func,
   input  logic           req_negative,
   output logic           req_ready,
   input  tcw_status_type status,
   output tcw_cmd_type    cmd
);

   tcw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FUNC_CHAR: begin
                     cmd.load_char = 1'b1;
                     state_in      = ST_EMIT;
                  end
                  FUNC_HEX_BYTE, FUNC_HEX_WORD, FUNC_HEX_DWORD: begin
                     cmd.load_hex = 1'b1;
                     state_in     = ST_EMIT;
                  end
                  FUNC_DECIMAL: begin
                     if (!req_negative) begin
                        cmd.load_dec = 1'b1;
                        state_in     = ST_CONVERT;
                     end
                  end
                  FUNC_SET_CURSOR: begin
                     cmd.set_cursor = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            cmd.convert_step = 1'b1;
            if (status.bits_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (status.top_zero && !status.count_one) begin
               cmd.skip_digit = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.count_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/tcw_datapath.sv */
module tcw_datapath
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  req_type        req_data,
   input  logic           csr_write_enable,
   input  logic [7:0]     csr_write_data,
   input  tcw_cmd_type    cmd,
   output tcw_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   logic [6:0]  cursor_col_ff, cursor_col_in;
   logic [4:0]  cursor_row_ff, cursor_row_in;
   logic [7:0]  colour_ff, colour_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [39:0] digit_ff, digit_in;
   logic [30:0] bin_ff, bin_in;
   logic [4:0]  bit_cnt_ff, bit_cnt_in;
   logic [3:0]  count_ff, count_in;
   logic        raw_ff, raw_in;

   logic [39:0] adjusted;
   logic [7:0]  emit_char;
   logic [11:0] address_full;
   logic        col_at_end;
   logic        row_at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         colour_ff     <= COLOUR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         colour_ff     <= colour_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      digit_ff    <= digit_in;
      bin_ff      <= bin_in;
      bit_cnt_ff  <= bit_cnt_in;
      count_ff    <= count_in;
      raw_ff      <= raw_in;
   end

   // add-3 correction of every BCD nibble before the shift
   always_comb begin
      for (int i = 0; i < 10; i++) begin
         adjusted[i*4 +: 4] = (digit_ff[i*4 +: 4] > 4'd4) ?
                              digit_ff[i*4 +: 4] + 4'd3 : digit_ff[i*4 +: 4];
      end
   end

   assign emit_char    = raw_ff ? digit_ff[39:32] : hex_digit(digit_ff[39:36]);
   assign address_full = 12'(cursor_row_ff) * 12'(COLUMNS) + 12'(cursor_col_ff);
   assign col_at_end   = (cursor_col_ff == 7'(COLUMNS - 1));
   assign row_at_end   = (cursor_row_ff == 5'(ROWS - 1));

   always_comb begin
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      colour_in     = csr_write_enable ? csr_write_data : colour_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      digit_in      = digit_ff;
      bin_in        = bin_ff;
      bit_cnt_in    = bit_cnt_ff;
      count_in      = count_ff;
      raw_in        = raw_ff;

      if (cmd.load_char) begin
         digit_in = {req_data.value[7:0], 32'h0};
         raw_in   = 1'b1;
         count_in = 4'd1;
      end

      if (cmd.load_hex) begin
         raw_in = 1'b0;
         case (req_data.func)
            FUNC_HEX_BYTE: begin
               digit_in = {req_data.value[7:0], 32'h0};
               count_in = 4'd2;
            end
            FUNC_HEX_WORD: begin
               digit_in = {req_data.value[15:0], 24'h0};
               count_in = 4'd4;
            end
            default: begin
               digit_in = {req_data.value, 8'h0};
               count_in = 4'd8;
            end
         endcase
      end

      if (cmd.load_dec) begin
         raw_in     = 1'b0;
         digit_in   = '0;
         bin_in     = req_data.value[30:0];
         bit_cnt_in = 5'd30;
         count_in   = 4'd10;
      end

      if (cmd.convert_step) begin
         digit_in   = {adjusted[38:0], bin_ff[30]};
         bin_in     = {bin_ff[29:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 5'd1;
      end

      if (cmd.skip_digit) begin
         digit_in = {digit_ff[35:0], 4'h0};
         count_in = count_ff - 4'd1;
      end

      if (cmd.set_cursor) begin
         cursor_col_in = (req_data.new_column > 7'(COLUMNS - 1)) ?
                         7'(COLUMNS - 1) : req_data.new_column;
         cursor_row_in = (req_data.new_row > 5'(ROWS - 1)) ?
                         5'(ROWS - 1) : req_data.new_row;
      end

      if (cmd.emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.serial_char = emit_char;
         rsp_data_in.last        = (count_ff == 4'd1);
         digit_in                = {digit_ff[35:0], 4'h0};
         count_in                = count_ff - 4'd1;
         if (emit_char == CHAR_NEWLINE) begin
            rsp_data_in.cell_write   = 1'b0;
            rsp_data_in.cell_address = '0;
            rsp_data_in.cell_entry   = '0;
            cursor_col_in            = '0;
            cursor_row_in            = row_at_end ? '0 : cursor_row_ff + 5'd1;
         end else begin
            rsp_data_in.cell_write   = 1'b1;
            rsp_data_in.cell_address = address_full[10:0];
            rsp_data_in.cell_entry   = {colour_ff, emit_char};
            if (col_at_end) begin
               cursor_col_in = '0;
               cursor_row_in = row_at_end ? '0 : cursor_row_ff + 5'd1;
            end else begin
               cursor_col_in = cursor_col_ff + 7'd1;
            end
         end
      end
   end

   assign status.top_zero  = (digit_ff[39:36] == 4'h0);
   assign status.count_one = (count_ff == 4'd1);
   assign status.bits_done = (bit_cnt_ff == 5'd0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      cursor_col_ff <= 7'(COLUMNS - 1))
      else $error("cursor column out of range");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      cursor_row_ff <= 5'(ROWS - 1))
      else $error("cursor row out of range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("item overwritten in output register");

   a_newline_no_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.serial_char == CHAR_NEWLINE) |->
      (!rsp_data_ff.cell_write && rsp_data_ff.cell_address == '0))
      else $error("newline wrote a cell");

endmodule

/* verif/text_console_writer_test.sv */
module text_console_writer_test;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
   localparam int SETTLE_CYCLES  = 60;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;

   // predicted console state
   logic [7:0] colour_model = COLOUR_RESET;
   logic [6:0] cursor_col = '0;
   logic [4:0] cursor_row = '0;

   rsp_type    expected_chars[$];
   rsp_type    request_chars[$];

   bit         sender_gaps = 1'b1;
   bit         receiver_stalls = 1'b1;
   int         burst_left = 0;
   logic [15:0] ready_pattern = '1;
   int         pattern_age = 0;

   int         errors = 0;
   int         results_checked = 0;
   int         colour_writes = 0;
   int         func_count[8];

   text_console_writer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic next_row();
      cursor_row = (cursor_row == ROWS - 1) ? 5'd0 : cursor_row + 5'd1;
   endtask

   task automatic print_char(input logic [7:0] ch);
      rsp_type c;
      c = '0;
      c.serial_char = ch;
      if (ch == CHAR_NEWLINE) begin
         cursor_col = '0;
         next_row();
      end else begin
         c.cell_write   = 1'b1;
         c.cell_address = 11'(cursor_row * COLUMNS + cursor_col);
         c.cell_entry   = {colour_model, ch};
         if (cursor_col == COLUMNS - 1) begin
            cursor_col = '0;
            next_row();
         end else begin
            cursor_col = cursor_col + 7'd1;
         end
      end
      request_chars.push_back(c);
   endtask

   task automatic predict_request(input req_type item);
      string       hex_chars;
      logic [31:0] v;
      logic [7:0]  digits[$];
      int          ndigits;
      hex_chars = "0123456789ABCDEF";
      request_chars.delete();
      v = item.value;
      func_count[item.func]++;
      case (item.func)
         FUNC_CHAR: print_char(v[7:0]);
         FUNC_HEX_BYTE, FUNC_HEX_WORD, FUNC_HEX_DWORD: begin
            ndigits = (item.func == FUNC_HEX_BYTE) ? 2 : (item.func == FUNC_HEX_WORD) ? 4 : 8;
            for (int i = ndigits - 1; i >= 0; i--)
               print_char(8'(hex_chars[(v >> (4 * i)) & 32'hF]));
         end
         FUNC_DECIMAL: begin
            if (v == 0) begin
               print_char(CHAR_ZERO);
            end else if (!v[31]) begin
               while (v != 0) begin
                  digits.push_front(CHAR_ZERO + 8'(v % 10));
                  v = v / 10;
               end
               foreach (digits[i]) print_char(digits[i]);
            end
         end
         FUNC_SET_CURSOR: begin
            cursor_col = (item.new_column > COLUMNS - 1) ? 7'(COLUMNS - 1) : item.new_column;
            cursor_row = (item.new_row > ROWS - 1) ? 5'(ROWS - 1) : item.new_row;
         end
         default: ;
      endcase
      if (request_chars.size() > 0) begin
         request_chars[request_chars.size() - 1].last = 1'b1;
         foreach (request_chars[i]) expected_chars.push_back(request_chars[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && req_valid && req_ready) predict_request(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_chars.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected item: expected none, actual %p", $time, rsp_data);
         end else begin
            want = expected_chars.pop_front();
            check_field("cell_write", want.cell_write, rsp_data.cell_write);
            check_field("cell_address", want.cell_address, rsp_data.cell_address);
            check_field("cell_entry", want.cell_entry, rsp_data.cell_entry);
            check_field("serial_char", want.serial_char, rsp_data.serial_char);
            check_field("last", want.last, rsp_data.last);
         end
      end
   end

   // receiver: rotating ready mask, reloaded with a new random pattern when its random age runs out
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         ready_pattern = 16'($urandom);
         pattern_age   = $urandom_range(20, 80);
      end else begin
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
         pattern_age--;
      end
      rsp_ready <= !receiver_stalls || ready_pattern[0];
   end

   initial begin : watchdog
      int stalled_cycles;
      stalled_cycles = 0;
      while (stalled_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
      $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic req_type make_request(input logic [2:0] func, input logic [31:0] value,
                                            input logic [6:0] col = '0,
                                            input logic [4:0] row = '0);
      req_type r;
      r.func       = func;
      r.value      = value;
      r.new_column = col;
      r.new_row    = row;
      return r;
   endfunction

   task automatic send_request(input req_type item);
      int gap;
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sender_gaps) begin
         if (burst_left > 0) burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 50) : $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colour(input logic [7:0] colour);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= colour;
      @(posedge clock);
      colour_model = colour;
      colour_writes++;
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_characters();
      send_request(make_request(FUNC_CHAR, 32'h0000_0041));
      send_request(make_request(FUNC_CHAR, 32'h0000_0000));
      send_request(make_request(FUNC_CHAR, 32'h0000_00FF));
      send_request(make_request(FUNC_CHAR, 32'hFFFF_FF0A));
      send_request(make_request(FUNC_CHAR, 32'hABCD_EF20));
   endtask

   task automatic test_hex();
      send_request(make_request(FUNC_HEX_BYTE, 32'hFFFF_FF00));
      send_request(make_request(FUNC_HEX_BYTE, 32'h0000_009A));
      send_request(make_request(FUNC_HEX_WORD, 32'h0000_FFFF));
      send_request(make_request(FUNC_HEX_WORD, 32'hFFFF_0000));
      send_request(make_request(FUNC_HEX_DWORD, 32'hFFFF_FFFF));
      send_request(make_request(FUNC_HEX_DWORD, 32'h0123_ABCD));
   endtask

   task automatic test_decimal();
      send_request(make_request(FUNC_DECIMAL, 32'd0));
      send_request(make_request(FUNC_DECIMAL, 32'd1));
      send_request(make_request(FUNC_DECIMAL, 32'h7FFF_FFFF));
      send_request(make_request(FUNC_DECIMAL, 32'd1000000000));
      send_request(make_request(FUNC_DECIMAL, 32'h8000_0000));
      send_request(make_request(FUNC_DECIMAL, 32'hFFFF_FFFF));
   endtask

   // last cell, column and row wrap, saturation, newline row wrap, unused codes
   task automatic test_cursor();
      send_request(make_request(FUNC_SET_CURSOR, '0, 7'd79, 5'd24));
      send_request(make_request(FUNC_CHAR, 32'h0000_005A));
      send_request(make_request(FUNC_SET_CURSOR, '1, 7'd127, 5'd31));
      send_request(make_request(FUNC_CHAR, {24'h0, CHAR_NEWLINE}));
      send_request(make_request(FUNC_SET_CURSOR, '0, 7'd79, 5'd3));
      send_request(make_request(FUNC_HEX_BYTE, 32'h0000_00AB));
      send_request(make_request(FUNC_SET_CURSOR, '0, 7'd0, 5'd0));
      send_request(make_request(FUNC_UNUSED_LO, '1, 7'd5, 5'd5));
      send_request(make_request(FUNC_UNUSED_HI, 32'h1234_5678, 7'd9, 5'd9));
   endtask

   function automatic req_type random_request();
      req_type r;
      int      pick;
      r.func       = FUNC_CHAR;
      r.value      = $urandom;
      r.new_column = 7'($urandom_range(0, 127));
      r.new_row    = 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         if ($urandom_range(0, 5) == 0) r.value[7:0] = CHAR_NEWLINE;
      end else if (pick < 50) begin
         r.func = FUNC_HEX_BYTE + 3'($urandom_range(0, 2));
      end else if (pick < 75) begin
         r.func = FUNC_DECIMAL;
         case ($urandom_range(0, 5))
            0: r.value = '0;
            1: r.value = $urandom | 32'h8000_0000;
            2: r.value = $urandom >> 1;
            default: r.value = $urandom >> $urandom_range(1, 31);
         endcase
      end else if (pick < 93) begin
         r.func = FUNC_SET_CURSOR;
         case ($urandom_range(0, 2))
            0: ;
            1: begin
               r.new_column = 7'($urandom_range(COLUMNS - 10, COLUMNS - 1));
               r.new_row    = 5'($urandom_range(ROWS - 3, ROWS - 1));
            end
            default: begin
               r.new_column = 7'($urandom_range(0, COLUMNS - 1));
               r.new_row    = 5'($urandom_range(0, ROWS - 1));
            end
         endcase
      end else begin
         r.func = $urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
      end
      return r;
   endfunction

   task automatic test_random_traffic(input int count, input logic [7:0] colour,
                                      input bit gaps, input bit stalls);
      req_type item;
      int      sent;
      write_colour(colour);
      sender_gaps     = gaps;
      receiver_stalls = stalls;
      sent = 0;
      while (sent < count) begin
         item = random_request();
         send_request(item);
         sent++;
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_characters();
      test_hex();
      test_decimal();
      test_cursor();
      test_random_traffic(60, 8'h00, 1'b0, 1'b0);
      test_random_traffic(100, 8'hFF, 1'b1, 1'b1);
      test_random_traffic(80, 8'($urandom), 1'b1, 1'b0);
      test_random_traffic(80, 8'($urandom), 1'b0, 1'b1);
      test_random_traffic(70, 8'($urandom), 1'b1, 1'b1);
      wait_idle();
      $display("Covered %0d requests: %0d char, %0d hex, %0d decimal, %0d cursor, %0d unused",
               func_count.sum(), func_count[FUNC_CHAR],
               func_count[FUNC_HEX_BYTE] + func_count[FUNC_HEX_WORD]
               + func_count[FUNC_HEX_DWORD],
               func_count[FUNC_DECIMAL], func_count[FUNC_SET_CURSOR],
               func_count[FUNC_UNUSED_LO] + func_count[FUNC_UNUSED_HI]);
      $display("Checked %0d printed characters across %0d colour settings, %0d errors",
               results_checked, colour_writes + 1, errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
hdl/tcw_pkg.sv
hdl/tcw_control.sv
hdl/tcw_datapath.sv
hdl/text_console_writer.sv
verif/text_console_writer_test.sv
